>>> sv/ste_pkg.sv
package ste_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int FILL_W       = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_CLR,
    S_DN_RD,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_PLACE,
    S_OUT_RD,
    S_OUT_LD,
    S_EMPTY
  } state_t;

  // Result of the shared comparator: a == b and a > b, both signed.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

>>> sv/ste_if.sv
interface ste_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        operation;
  logic signed [ste_pkg::DATA_W-1:0] key_value;
  logic signed [ste_pkg::DATA_W-1:0] replacement;

  modport source (output valid, operation, key_value, replacement, input ready);
  modport sink (input valid, operation, key_value, replacement, output ready);
endinterface

interface ste_res_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [ste_pkg::FILL_W-1:0]        fill_count;
  logic                              entry_present;
  logic signed [ste_pkg::DATA_W-1:0] entry_data;
  logic                              last_result;

  modport source (output valid, status, fill_count, entry_present, entry_data, last_result,
                  input ready);
  modport sink (input valid, status, fill_count, entry_present, entry_data, last_result,
                output ready);
endinterface

>>> sv/ste_ram.sv
module ste_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ste_cmp.sv
module ste_cmp (
  input  logic signed [ste_pkg::DATA_W-1:0] a,
  input  logic signed [ste_pkg::DATA_W-1:0] b,
  output ste_pkg::cmp_res_t                 res
);

  always_comb begin
    res.eq = (a == b);
    res.gt = (a > b);
  end

endmodule

>>> sv/ste_engine.sv
module ste_engine #(
  parameter int CAPACITY = ste_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ste_req_if.sink                           req,
  ste_res_if.source                         res,
  // Table memory and shared comparator.
  output logic                              mem_we,
  output logic [$clog2(CAPACITY)-1:0]       mem_waddr,
  output logic [ste_pkg::DATA_W-1:0]        mem_wdata,
  output logic                              mem_re,
  output logic [$clog2(CAPACITY)-1:0]       mem_raddr,
  input  logic [ste_pkg::DATA_W-1:0]        mem_rdata,
  output logic signed [ste_pkg::DATA_W-1:0] cmp_a,
  output logic signed [ste_pkg::DATA_W-1:0] cmp_b,
  input  ste_pkg::cmp_res_t                 cmp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = ste_pkg::DATA_W;

  ste_pkg::state_t  state, state_next;
  ste_pkg::status_t status, status_next;
  logic [1:0]       op, op_next;
  logic [DW-1:0]    val, val_next;
  logic [DW-1:0]    rep, rep_next;
  logic [CW-1:0]    pos, pos_next;
  logic [CW-1:0]    fidx, fidx_next;
  logic [CW-1:0]    count, count_next;
  logic             go_stream;
  logic             out_free;
  logic             res_load;
  logic             res_present_d;
  logic [DW-1:0]    res_data_d;
  logic             res_last_d;

  logic                       res_valid;
  ste_pkg::status_t           res_status;
  logic [ste_pkg::FILL_W-1:0] res_fill;
  logic                       res_present;
  logic [DW-1:0]              res_data;
  logic                       res_last;

  assign req.ready = (state == ste_pkg::S_IDLE);
  assign out_free  = !res_valid || res.ready;

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.fill_count    = res_fill;
  assign res.entry_present = res_present;
  assign res.entry_data    = res_data;
  assign res.last_result   = res_last;

  // The comparator sees the word read back first, except when a value rises.
  assign cmp_a = (state == ste_pkg::S_UP_CMP) ? val : mem_rdata;
  assign cmp_b = (state == ste_pkg::S_UP_CMP) ? mem_rdata : val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ste_pkg::S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    op     <= op_next;
    val    <= val_next;
    rep    <= rep_next;
    pos    <= pos_next;
    fidx   <= fidx_next;
    if (res_load) begin
      res_status  <= status;
      res_fill    <= ste_pkg::FILL_W'(count);
      res_present <= res_present_d;
      res_data    <= res_data_d;
      res_last    <= res_last_d;
    end
  end

  always_comb begin
    state_next    = state;
    status_next   = status;
    op_next       = op;
    val_next      = val;
    rep_next      = rep;
    pos_next      = pos;
    fidx_next     = fidx;
    count_next    = count;
    go_stream     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pos[AW-1:0];
    mem_wdata     = val;
    mem_re        = 1'b0;
    mem_raddr     = pos[AW-1:0];
    res_load      = 1'b0;
    res_present_d = 1'b1;
    res_data_d    = mem_rdata;
    res_last_d    = 1'b0;

    unique case (state)
      ste_pkg::S_IDLE: begin
        if (req.valid) begin
          op_next     = req.operation;
          val_next    = req.key_value;
          rep_next    = req.replacement;
          status_next = ste_pkg::STAT_DONE;
          if (req.operation == ste_pkg::OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              status_next = ste_pkg::STAT_FULL;
              go_stream   = 1'b1;
            end else begin
              pos_next   = count;
              state_next = ste_pkg::S_DN_RD;
            end
          end else if (req.operation == ste_pkg::OP_DELETE ||
                       req.operation == ste_pkg::OP_UPDATE) begin
            pos_next   = '0;
            state_next = ste_pkg::S_FIND_RD;
          end else begin
            go_stream = 1'b1;
          end
        end
      end

      ste_pkg::S_FIND_RD: begin
        if (pos == count) begin
          status_next = ste_pkg::STAT_NOT_FOUND;
          go_stream   = 1'b1;
        end else begin
          mem_re     = 1'b1;
          state_next = ste_pkg::S_FIND_CMP;
        end
      end

      ste_pkg::S_FIND_CMP: begin
        if (cmp.eq) begin
          if (op == ste_pkg::OP_DELETE) begin
            state_next = ste_pkg::S_DEL_RD;
          end else begin
            fidx_next  = pos;
            val_next   = rep;
            state_next = ste_pkg::S_DN_RD;
          end
        end else begin
          pos_next   = pos + CW'(1);
          state_next = ste_pkg::S_FIND_RD;
        end
      end

      ste_pkg::S_DEL_RD: begin
        if (pos + CW'(1) == count) begin
          state_next = ste_pkg::S_CLR;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(pos + CW'(1));
          state_next = ste_pkg::S_DEL_WR;
        end
      end

      ste_pkg::S_DEL_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        pos_next   = pos + CW'(1);
        state_next = ste_pkg::S_DEL_RD;
      end

      ste_pkg::S_CLR: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(count - CW'(1));
        mem_wdata  = '0;
        count_next = count - CW'(1);
        go_stream  = 1'b1;
      end

      // Moving down: entries above the value shift up one slot each step.
      ste_pkg::S_DN_RD: begin
        if (pos == '0) begin
          if (op == ste_pkg::OP_UPDATE && pos == fidx) begin
            state_next = ste_pkg::S_UP_RD;
          end else begin
            state_next = ste_pkg::S_PLACE;
          end
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(pos - CW'(1));
          state_next = ste_pkg::S_DN_CMP;
        end
      end

      ste_pkg::S_DN_CMP: begin
        if (cmp.gt) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata;
          pos_next   = pos - CW'(1);
          state_next = ste_pkg::S_DN_RD;
        end else if (op == ste_pkg::OP_UPDATE && pos == fidx) begin
          state_next = ste_pkg::S_UP_RD;
        end else begin
          state_next = ste_pkg::S_PLACE;
        end
      end

      // Moving up is only tried when an updated value did not move down.
      ste_pkg::S_UP_RD: begin
        if (pos + CW'(1) == count) begin
          state_next = ste_pkg::S_PLACE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(pos + CW'(1));
          state_next = ste_pkg::S_UP_CMP;
        end
      end

      ste_pkg::S_UP_CMP: begin
        if (cmp.gt) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata;
          pos_next   = pos + CW'(1);
          state_next = ste_pkg::S_UP_RD;
        end else begin
          state_next = ste_pkg::S_PLACE;
        end
      end

      ste_pkg::S_PLACE: begin
        mem_we = 1'b1;
        if (op == ste_pkg::OP_INSERT) begin
          count_next = count + CW'(1);
        end
        go_stream = 1'b1;
      end

      ste_pkg::S_OUT_RD: begin
        if (out_free) begin
          mem_re     = 1'b1;
          state_next = ste_pkg::S_OUT_LD;
        end
      end

      ste_pkg::S_OUT_LD: begin
        res_load   = 1'b1;
        res_last_d = (pos + CW'(1) == count);
        pos_next   = pos + CW'(1);
        state_next = res_last_d ? ste_pkg::S_IDLE : ste_pkg::S_OUT_RD;
      end

      ste_pkg::S_EMPTY: begin
        if (out_free) begin
          res_load      = 1'b1;
          res_present_d = 1'b0;
          res_data_d    = '0;
          res_last_d    = 1'b1;
          state_next    = ste_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ste_pkg::S_IDLE;
      end
    endcase

    if (go_stream) begin
      pos_next   = '0;
      state_next = (count_next == '0) ? ste_pkg::S_EMPTY : ste_pkg::S_OUT_RD;
    end
  end

endmodule

>>> sv/sorted_table_engine_top.sv
// Sorted table of signed 32-bit values kept in ascending order with a fill count.
// Requests arrive as words on req: operation (insert, delete, update), key_value and
// replacement. A request is taken only while the block is idle; req.ready stays low
// while one request is searched, shifted and streamed.
// After every request the block sends the whole table on res, one word per entry in
// ascending order, each with the status and the new count; last_result marks the
// final word. An empty table gives a single word with entry_present low.
// All work goes through one table memory with a registered read port and one shared
// comparator: each search or shift step is a read, then a compare and, when shifting,
// a write; each streamed entry is read, then loaded into the output register. The last
// result sits in an output register, so the next request can be taken while it still
// waits. When res.ready is low the stream simply pauses; nothing is lost.
// Reset clears the count to zero; table contents are not cleared, since only
// entries below the count are ever read.
module sorted_table_engine_top #(
  parameter int CAPACITY = ste_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ste_req_if.sink   req,
  ste_res_if.source res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int DW = ste_pkg::DATA_W;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [DW-1:0]        mem_rdata;
  logic signed [DW-1:0] cmp_a;
  logic signed [DW-1:0] cmp_b;
  ste_pkg::cmp_res_t    cmp;

  ste_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp       (cmp)
  );

  ste_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ste_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CAPACITY     = ste_pkg::CAPACITY_DEF;
  localparam int DATA_W       = ste_pkg::DATA_W;
  localparam int FILL_W       = ste_pkg::FILL_W;
  localparam int RANDOM_ITEMS = 130;
  localparam int CALM_ITEMS   = 25;
  localparam int HOLD_AT_ITEM = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;

  // Operation code 3 has no meaning; the block must stream the table unchanged.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

  typedef struct packed {
    ste_pkg::status_t          status;
    logic [FILL_W-1:0]         fill;
    logic                      present;
    logic signed [DATA_W-1:0]  data;
    logic                      last;
  } table_word_t;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [DATA_W-1:0]  key;
    logic signed [DATA_W-1:0]  rep;
    logic                      typed;
    ste_pkg::status_t          t_status;
    logic [FILL_W-1:0]         t_fill;
  } directed_row_t;

  logic clk;
  logic rst;

  ste_req_if req_ch ();
  ste_res_if res_ch ();

  sorted_table_engine_top #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Shadow copy of the table, updated when a request is accepted.
  logic signed [DATA_W-1:0] sorted_vals [CAPACITY];
  int                       num_vals = 0;
  table_word_t              table_words [$];
  int                       mismatches = 0;
  bit                       calm = 1'b0;
  bit                       hold_res = 1'b0;

  // Rows with typed set carry a status and count that are obvious by inspection.
  directed_row_t directed_rows [19] = '{
    '{ste_pkg::OP_DELETE, 32'sd0,   32'sd0,  1'b1, ste_pkg::STAT_NOT_FOUND, 6'd0},
    '{ste_pkg::OP_UPDATE, 32'sd7,   32'sd9,  1'b1, ste_pkg::STAT_NOT_FOUND, 6'd0},
    '{OP_UNUSED,          32'sd3,   32'sd4,  1'b1, ste_pkg::STAT_DONE,      6'd0},
    '{ste_pkg::OP_INSERT, 32'sd0,   32'sd0,  1'b1, ste_pkg::STAT_DONE,      6'd1},
    '{ste_pkg::OP_INSERT, MAX_VAL,  MIN_VAL, 1'b1, ste_pkg::STAT_DONE,      6'd2},
    '{ste_pkg::OP_INSERT, MIN_VAL,  MAX_VAL, 1'b1, ste_pkg::STAT_DONE,      6'd3},
    '{ste_pkg::OP_INSERT, 32'sd0,   32'sd0,  1'b1, ste_pkg::STAT_DONE,      6'd4},
    '{ste_pkg::OP_INSERT, -32'sd1,  32'sd0,  1'b1, ste_pkg::STAT_DONE,      6'd5},
    '{ste_pkg::OP_INSERT, 32'sd1,   32'sd0,  1'b1, ste_pkg::STAT_DONE,      6'd6},
    '{ste_pkg::OP_UPDATE, 32'sd0,   MAX_VAL, 1'b0, ste_pkg::STAT_DONE,      6'd0},
    '{ste_pkg::OP_UPDATE, MIN_VAL,  32'sd5,  1'b0, ste_pkg::STAT_DONE,      6'd0},
    '{ste_pkg::OP_DELETE, 32'sd0,   32'sd0,  1'b0, ste_pkg::STAT_DONE,      6'd0},
    '{ste_pkg::OP_DELETE, 32'sd555, 32'sd0,  1'b1, ste_pkg::STAT_NOT_FOUND, 6'd5},
    '{ste_pkg::OP_UPDATE, 32'sd555, 32'sd1,  1'b1, ste_pkg::STAT_NOT_FOUND, 6'd5},
    '{OP_UNUSED,          -32'sd1,  MIN_VAL, 1'b1, ste_pkg::STAT_DONE,      6'd5},
    '{ste_pkg::OP_DELETE, MAX_VAL,  32'sd0,  1'b0, ste_pkg::STAT_DONE,      6'd0},
    '{ste_pkg::OP_UPDATE, -32'sd1,  -32'sd1, 1'b0, ste_pkg::STAT_DONE,      6'd0},
    '{ste_pkg::OP_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, ste_pkg::STAT_DONE, 6'd0},
    '{ste_pkg::OP_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, ste_pkg::STAT_DONE, 6'd0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int find_first(input logic signed [DATA_W-1:0] key);
    for (int i = 0; i < num_vals; i++) begin
      if (sorted_vals[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and queues every word of the stream it causes.
  task automatic apply_request(input logic [1:0] op, input logic signed [DATA_W-1:0] key,
                               input logic signed [DATA_W-1:0] rep, input logic typed,
                               input ste_pkg::status_t t_status,
                               input logic [FILL_W-1:0] t_fill);
    ste_pkg::status_t         st;
    logic [FILL_W-1:0]        fill;
    int                       pos;
    int                       hit;
    logic signed [DATA_W-1:0] tmp;
    st = ste_pkg::STAT_DONE;
    case (op)
      ste_pkg::OP_INSERT: begin
        if (num_vals >= CAPACITY) begin
          st = ste_pkg::STAT_FULL;
        end else begin
          // Equal values stay ahead of the new one.
          pos = num_vals;
          while (pos > 0 && sorted_vals[pos-1] > key) begin
            sorted_vals[pos] = sorted_vals[pos-1];
            pos--;
          end
          sorted_vals[pos] = key;
          num_vals++;
        end
      end
      ste_pkg::OP_DELETE: begin
        hit = find_first(key);
        if (hit < 0) begin
          st = ste_pkg::STAT_NOT_FOUND;
        end else begin
          for (pos = hit; pos + 1 < num_vals; pos++) sorted_vals[pos] = sorted_vals[pos+1];
          num_vals--;
          sorted_vals[num_vals] = '0;
        end
      end
      ste_pkg::OP_UPDATE: begin
        hit = find_first(key);
        if (hit < 0) begin
          st = ste_pkg::STAT_NOT_FOUND;
        end else begin
          pos = hit;
          sorted_vals[pos] = rep;
          while (pos > 0 && sorted_vals[pos-1] > sorted_vals[pos]) begin
            tmp = sorted_vals[pos-1];
            sorted_vals[pos-1] = sorted_vals[pos];
            sorted_vals[pos] = tmp;
            pos--;
          end
          while (pos + 1 < num_vals && sorted_vals[pos] > sorted_vals[pos+1]) begin
            tmp = sorted_vals[pos+1];
            sorted_vals[pos+1] = sorted_vals[pos];
            sorted_vals[pos] = tmp;
            pos++;
          end
        end
      end
      default: begin
      end
    endcase
    fill = FILL_W'(num_vals);
    if (typed) begin
      st = t_status;
      fill = t_fill;
    end
    if (num_vals == 0) begin
      table_words.push_back('{st, fill, 1'b0, '0, 1'b1});
    end else begin
      for (int k = 0; k < num_vals; k++) begin
        table_words.push_back('{st, fill, 1'b1, sorted_vals[k], k == num_vals - 1});
      end
    end
  endtask

  task automatic offer_request(input logic [1:0] op, input logic signed [DATA_W-1:0] key,
                               input logic signed [DATA_W-1:0] rep, input logic typed,
                               input ste_pkg::status_t t_status,
                               input logic [FILL_W-1:0] t_fill);
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.key_value   <= key;
    req_ch.replacement <= rep;
    do @(posedge clk); while (!req_ch.ready);
    apply_request(op, key, rep, typed, t_status, t_fill);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Mix of arbitrary words, small values that collide often, and the extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 16)) - 8;
      7:          return MAX_VAL;
      8:          return MIN_VAL;
      default:    return '0;
    endcase
  endfunction

  task automatic check_word();
    table_word_t want;
    if (table_words.size() == 0) begin
      report($sformatf("unexpected word, entry_data %0d", res_ch.entry_data));
      return;
    end
    want = table_words.pop_front();
    if (res_ch.status !== want.status)
      report($sformatf("status %0d, expected %0d", res_ch.status, want.status));
    if (res_ch.fill_count !== want.fill)
      report($sformatf("fill_count %0d, expected %0d", res_ch.fill_count, want.fill));
    if (res_ch.entry_present !== want.present)
      report($sformatf("entry_present %b, expected %b", res_ch.entry_present, want.present));
    if (res_ch.entry_data !== want.data)
      report($sformatf("entry_data %0d, expected %0d", res_ch.entry_data, want.data));
    if (res_ch.last_result !== want.last)
      report($sformatf("last_result %b, expected %b", res_ch.last_result, want.last));
  endtask

  // Result side: checks each word and stalls in random bursts, plus one long hold.
  initial begin : res_side
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) check_word();
      if (hold_res && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : req_side
    logic [1:0]               op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] rep;
    int                       roll;
    int                       full_hits;
    bit                       growing;
    bit                       was_full;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= ste_pkg::OP_INSERT;
    req_ch.key_value   <= '0;
    req_ch.replacement <= '0;
    for (int i = 0; i < CAPACITY; i++) sorted_vals[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].rep,
                    directed_rows[i].typed, directed_rows[i].t_status,
                    directed_rows[i].t_fill);
      maybe_pause();
    end

    // Alternate between filling the table until inserts are refused and draining it.
    growing = 1'b1;
    full_hits = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if (n == HOLD_AT_ITEM) hold_res = 1'b1;
      roll = $urandom_range(0, 99);
      if (growing)
        op = (roll < 72) ? ste_pkg::OP_INSERT : (roll < 86) ? ste_pkg::OP_DELETE :
             (roll < 97) ? ste_pkg::OP_UPDATE : OP_UNUSED;
      else
        op = (roll < 20) ? ste_pkg::OP_INSERT : (roll < 85) ? ste_pkg::OP_DELETE :
             (roll < 97) ? ste_pkg::OP_UPDATE : OP_UNUSED;
      if (op != ste_pkg::OP_INSERT && num_vals > 0 && $urandom_range(0, 9) < 8)
        key = sorted_vals[$urandom_range(0, num_vals - 1)];
      else
        key = pick_value();
      rep = pick_value();
      was_full = (num_vals == CAPACITY);
      offer_request(op, key, rep, 1'b0, ste_pkg::STAT_DONE, '0);
      if (was_full && op == ste_pkg::OP_INSERT) full_hits++;
      if (growing && full_hits >= 3) begin
        growing = 1'b0;
        full_hits = 0;
      end else if (!growing && num_vals == 0) begin
        growing = 1'b1;
      end
      maybe_pause();
    end
    req_ch.valid <= 1'b0;

    while (table_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && table_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ste_pkg.sv
sv/ste_if.sv
sv/ste_ram.sv
sv/ste_cmp.sv
sv/ste_engine.sv
sv/sorted_table_engine_top.sv
tb/sv/tb.sv
